// ===== rtl/msat_pkg.sv =====
// Shared types and constants for the multi-slot alarm timer.
`timescale 1ns / 1ps
`default_nettype none
package msat_pkg;

  localparam int DELAY_W    = 23;
  localparam int DWORD_W    = 24;
  localparam int ID_W       = 8;
  localparam int AUX_W      = 32;
  localparam int PERIOD_POS = 23;

  // Command and result kind codes.
  localparam logic CMD_ACTIVATE  = 1'b0;
  localparam logic CMD_TICK      = 1'b1;
  localparam logic KIND_FIRED    = 1'b0;
  localparam logic KIND_OVERFLOW = 1'b1;

  // One input transaction.
  typedef struct packed {
    logic               command;
    logic [ID_W-1:0]    event_id;
    logic [DWORD_W-1:0] delay_word;
    logic [AUX_W-1:0]   aux_data;
  } in_t;

  // One result transaction.
  typedef struct packed {
    logic             kind;
    logic [ID_W-1:0]  fired_id;
    logic [AUX_W-1:0] fired_data;
    logic             last;
  } out_t;

  // Pass that travels down the row of slot cells.
  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_SEEK  = 2'd1,
    OP_ALLOC = 2'd2
  } pass_op_t;

  // Packet handed from one cell to the next.
  typedef struct packed {
    logic               valid;
    pass_op_t           op;
    logic [ID_W-1:0]    id;
    logic               periodic;
    logic [DELAY_W-1:0] delay;
    logic [AUX_W-1:0]   aux;
    logic               found;  // some slot matched the id
    logic               done;   // a slot was reprogrammed or allocated
  } pkt_t;

  // Fire request from the cell that holds a tick packet.
  typedef struct packed {
    logic             req;
    logic             last;
    logic [ID_W-1:0]  id;
    logic [AUX_W-1:0] aux;
  } fire_t;

endpackage
`default_nettype wire

// ===== rtl/msat_cell.sv =====
// One alarm slot: holds the slot state and forwards the pass packet to its neighbor.
`timescale 1ns / 1ps
`default_nettype none
module msat_cell (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          adv,
  input  msat_pkg::pkt_t     pkt_i,
  output msat_pkg::pkt_t     pkt_o,
  input  wire logic          due_after_i,
  output logic               due_after_o,
  output msat_pkg::fire_t    fire_o
);
  import msat_pkg::*;

  logic [ID_W-1:0]    id_r, id_nxt;
  logic               active_r, active_nxt;
  logic               periodic_r, periodic_nxt;
  logic [DELAY_W-1:0] delay_r, delay_nxt;
  logic [AUX_W-1:0]   aux_r, aux_nxt;
  logic [DELAY_W-1:0] elapsed_r, elapsed_nxt;
  pkt_t               pkt_r, pkt_nxt;
  logic               due;
  logic               visit;

  // The slot is due when its delay is reached on this tick.
  assign due         = active_r &&
                       ({1'b0, delay_r} <= ({1'b0, elapsed_r} + {{DELAY_W{1'b0}}, 1'b1}));
  assign due_after_o = due_after_i | due;
  assign visit       = pkt_i.valid;

  // Fire request toward the result register; last when no later slot is due.
  always_comb begin
    fire_o.req  = visit && (pkt_i.op == OP_TICK) && due;
    fire_o.last = !due_after_i;
    fire_o.id   = id_r;
    fire_o.aux  = aux_r;
  end

  // Slot update for the packet that sits at this cell.
  always_comb begin
    id_nxt       = id_r;
    active_nxt   = active_r;
    periodic_nxt = periodic_r;
    delay_nxt    = delay_r;
    aux_nxt      = aux_r;
    elapsed_nxt  = elapsed_r;
    pkt_nxt      = pkt_i;
    if (visit) begin
      case (pkt_i.op)
        OP_TICK: begin
          if (active_r) begin
            if (due) begin
              if (periodic_r) begin
                elapsed_nxt = '0;
              end else begin
                active_nxt = 1'b0;
              end
            end else begin
              elapsed_nxt = elapsed_r + {{(DELAY_W-1){1'b0}}, 1'b1};
            end
          end
        end
        OP_SEEK: begin
          if (!pkt_i.done && (id_r == pkt_i.id)) begin
            pkt_nxt.found = 1'b1;
            elapsed_nxt   = '0;
            if (pkt_i.delay != '0) begin
              periodic_nxt = pkt_i.periodic;
              delay_nxt    = pkt_i.delay;
              active_nxt   = 1'b1;
              pkt_nxt.done = 1'b1;
            end else begin
              active_nxt = 1'b0;
            end
          end
        end
        OP_ALLOC: begin
          if (!pkt_i.done && !active_r) begin
            id_nxt       = pkt_i.id;
            periodic_nxt = pkt_i.periodic;
            delay_nxt    = pkt_i.delay;
            aux_nxt      = pkt_i.aux;
            active_nxt   = 1'b1;
            elapsed_nxt  = '0;
            pkt_nxt.done = 1'b1;
          end
        end
        default: begin
          pkt_nxt = pkt_i;
        end
      endcase
    end
  end

  // Control state and packet stage; the whole row moves together on adv.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      id_r       <= '0;
      active_r   <= 1'b0;
      periodic_r <= 1'b0;
      aux_r      <= '0;
      elapsed_r  <= '0;
      pkt_r      <= '0;
    end else if (adv) begin
      id_r       <= id_nxt;
      active_r   <= active_nxt;
      periodic_r <= periodic_nxt;
      aux_r      <= aux_nxt;
      elapsed_r  <= elapsed_nxt;
      pkt_r      <= pkt_nxt;
    end
  end

  // The delay is always written before it is read, so it needs no reset.
  always_ff @(posedge clk) begin
    if (adv) begin
      delay_r <= delay_nxt;
    end
  end

  assign pkt_o = pkt_r;

endmodule
`default_nettype wire

// ===== rtl/multi_slot_alarm_timer_core.sv =====
// Top level of the multi-slot alarm timer: row of slot cells, pass control and result register.
`timescale 1ns / 1ps
`default_nettype none
// The alarm table is a row of SLOTS cells, one slot each, and every input transaction
// becomes a packet that moves one cell per cycle down the row, unless the row is held;
// one transaction is handled at a time. A transaction is accepted only while the result
// register is empty or being read in that cycle, so the first cell can always hand a
// fired alarm onward. A tick holds the row while a fired alarm waits on a full result
// register. An activate or cancel makes one pass when the id matches; a new allocation
// walks the row a second time, and an overflow then loads its result once the result
// register is free. Results leave through a one-deep register, with last marking the
// final result of a transaction.
module multi_slot_alarm_timer_core #(
  parameter int SLOTS = 4
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  msat_pkg::in_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output msat_pkg::out_t out_data
);
  import msat_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BUSY,
    ST_OVF
  } state_t;

  state_t state_r;
  logic   out_valid_r;
  out_t   out_data_r;

  pkt_t   chain [SLOTS+1];
  logic   due_after [SLOTS+1];
  fire_t  fire [SLOTS];
  pkt_t   tail;
  pkt_t   inject;
  logic   accept;
  logic   realloc;
  logic   out_free;
  logic   fire_any;
  fire_t  fire_sel;
  logic   adv;

  // A new transaction enters only when the first cell could pass a fired alarm on at once.
  assign in_ready  = (state_r == ST_IDLE) && out_free;
  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign tail      = chain[SLOTS];
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A seek pass that found nothing comes back for an allocation pass.
  assign realloc = (state_r == ST_BUSY) && tail.valid && (tail.op == OP_SEEK) &&
                   !tail.found && (tail.delay != '0);

  // Packet entering the first cell.
  always_comb begin
    inject = '0;
    if (accept) begin
      inject.valid    = 1'b1;
      inject.op       = (in_data.command == CMD_TICK) ? OP_TICK : OP_SEEK;
      inject.id       = in_data.event_id;
      inject.periodic = in_data.delay_word[PERIOD_POS];
      inject.delay    = in_data.delay_word[DELAY_W-1:0];
      inject.aux      = in_data.aux_data;
    end else if (realloc) begin
      inject       = tail;
      inject.op    = OP_ALLOC;
      inject.found = 1'b0;
      inject.done  = 1'b0;
    end
  end

  assign chain[0]         = inject;
  assign due_after[SLOTS] = 1'b0;

  // The row of slot cells.
  for (genvar k = 0; k < SLOTS; k++) begin : g_cell
    msat_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .adv         (adv),
      .pkt_i       (chain[k]),
      .pkt_o       (chain[k+1]),
      .due_after_i (due_after[k+1]),
      .due_after_o (due_after[k]),
      .fire_o      (fire[k])
    );
  end

  // At most one cell holds the packet, so at most one fire request is raised.
  always_comb begin
    fire_any = 1'b0;
    fire_sel = '0;
    for (int k = 0; k < SLOTS; k++) begin
      if (fire[k].req) begin
        fire_any = 1'b1;
        fire_sel = fire[k];
      end
    end
  end

  // The row holds still while a fired alarm cannot reach the result register.
  assign adv = !(fire_any && !out_free);

  // Transaction control and the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      out_data_r  <= '0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            state_r <= ST_BUSY;
          end
        end
        ST_BUSY: begin
          if (tail.valid && !realloc) begin
            if ((tail.op == OP_ALLOC) && !tail.done) begin
              state_r <= ST_OVF;
            end else begin
              state_r <= ST_IDLE;
            end
          end
        end
        ST_OVF: begin
          if (out_free) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase

      if (fire_any && out_free) begin
        out_valid_r           <= 1'b1;
        out_data_r.kind       <= KIND_FIRED;
        out_data_r.fired_id   <= fire_sel.id;
        out_data_r.fired_data <= fire_sel.aux;
        out_data_r.last       <= fire_sel.last;
      end else if ((state_r == ST_OVF) && out_free) begin
        out_valid_r           <= 1'b1;
        out_data_r.kind       <= KIND_OVERFLOW;
        out_data_r.fired_id   <= '0;
        out_data_r.fired_data <= '0;
        out_data_r.last       <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// ===== bench/tb.sv =====
// Self-checking testbench for the multi-slot alarm timer core.
`timescale 1ns / 1ps
module tb;
  import msat_pkg::*;

  localparam int NSLOTS = 4;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  multi_slot_alarm_timer_core #(.SLOTS(NSLOTS)) u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  always #5 clk = ~clk;

  // Shadow copy of the alarm table.
  logic [ID_W-1:0] slot_tag [NSLOTS];
  logic slot_on [NSLOTS];
  logic slot_rep [NSLOTS];
  logic [DELAY_W-1:0] slot_len [NSLOTS];
  logic [AUX_W-1:0] slot_word [NSLOTS];
  logic [DELAY_W-1:0] slot_cnt [NSLOTS];

  in_t pending_cmds[$];
  out_t alarm_results_q[$];
  int n_cmds = 0;
  int items_taken = 0;
  int fail_count = 0;
  int burst_left = 0;
  int gap_left = 0;
  int cyc = 0;
  int hold_left = 0;
  logic hold_done = 1'b0;
  logic [15:0] stall_pat = 16'b1101_0110_0111_0010;

  // Update the shadow table with one accepted transaction and queue the alarms it causes.
  task automatic apply_timer_cmd(input in_t it);
    logic [DELAY_W-1:0] len;
    logic per;
    logic found;
    logic placed;
    int n0;
    out_t r;
    n0 = alarm_results_q.size();
    len = it.delay_word[DELAY_W-1:0];
    per = it.delay_word[PERIOD_POS];
    if (it.command == CMD_TICK) begin
      for (int i = 0; i < NSLOTS; i++) begin
        if (!slot_on[i]) continue;
        if ({1'b0, slot_len[i]} <= {1'b0, slot_cnt[i]} + 24'd1) begin
          r.kind = KIND_FIRED;
          r.fired_id = slot_tag[i];
          r.fired_data = slot_word[i];
          r.last = 1'b0;
          alarm_results_q.push_back(r);
          if (slot_rep[i]) slot_cnt[i] = '0;
          else slot_on[i] = 1'b0;
        end else begin
          slot_cnt[i] = slot_cnt[i] + 1'b1;
        end
      end
    end else begin
      found = 1'b0;
      // Matching slots are reprogrammed (first one) or all cancelled.
      for (int i = 0; i < NSLOTS; i++) begin
        if (slot_tag[i] != it.event_id) continue;
        found = 1'b1;
        if (len != 0) begin
          slot_rep[i] = per;
          slot_len[i] = len;
          slot_on[i] = 1'b1;
          slot_cnt[i] = '0;
          break;
        end
        slot_on[i] = 1'b0;
        slot_cnt[i] = '0;
      end
      // No match: take the first idle slot, or report a full table.
      if (!found && len != 0) begin
        placed = 1'b0;
        for (int i = 0; i < NSLOTS; i++) begin
          if (!slot_on[i]) begin
            placed = 1'b1;
            slot_tag[i] = it.event_id;
            slot_rep[i] = per;
            slot_word[i] = it.aux_data;
            slot_len[i] = len;
            slot_on[i] = 1'b1;
            slot_cnt[i] = '0;
            break;
          end
        end
        if (!placed) begin
          r.kind = KIND_OVERFLOW;
          r.fired_id = '0;
          r.fired_data = '0;
          r.last = 1'b0;
          alarm_results_q.push_back(r);
        end
      end
    end
    if (alarm_results_q.size() > n0) begin
      r = alarm_results_q[alarm_results_q.size() - 1];
      r.last = 1'b1;
      alarm_results_q[alarm_results_q.size() - 1] = r;
    end
  endtask

  function automatic in_t mk_cmd(logic cmd, logic [ID_W-1:0] id, logic [DWORD_W-1:0] word,
                                 logic [AUX_W-1:0] aux);
    in_t it;
    it.command = cmd;
    it.event_id = id;
    it.delay_word = word;
    it.aux_data = aux;
    return it;
  endfunction

  // Driver: sends bursts of transactions with random gaps and predicts each accepted one.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      burst_left <= $urandom_range(1, 8);
      gap_left <= 0;
    end else begin
      if (in_valid && in_ready) begin
        apply_timer_cmd(in_data);
        items_taken <= items_taken + 1;
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending_cmds.size() > 0) begin
          in_valid <= 1'b1;
          in_data <= pending_cmds.pop_front();
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 8);
            // A stretch in the middle of the run goes without gaps.
            gap_left <= (items_taken >= 60 && items_taken < 110) ? 0 : $urandom_range(0, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: one long hold-off mid-run, otherwise rotating stall phases.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      cyc <= 0;
    end else begin
      cyc <= cyc + 1;
      if (!hold_done && items_taken >= 140) begin
        hold_done <= 1'b1;
        hold_left <= 250;
        out_ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else begin
        case ((cyc / 400) % 3)
          0: out_ready <= 1'b1;
          1: out_ready <= ($urandom_range(0, 9) < 7);
          default: out_ready <= stall_pat[cyc % 16];
        endcase
      end
    end
  end

  // Monitor: compare every result transaction with the oldest predicted one.
  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (alarm_results_q.size() == 0) begin
        $error("unexpected result: kind %0h id %0h data %0h last %0h",
               out_data.kind, out_data.fired_id, out_data.fired_data, out_data.last);
        fail_count++;
      end else begin
        want = alarm_results_q.pop_front();
        if (out_data.kind !== want.kind) begin
          $error("kind: expected %0h, got %0h", want.kind, out_data.kind);
          fail_count++;
        end
        if (out_data.fired_id !== want.fired_id) begin
          $error("fired_id: expected %0h, got %0h", want.fired_id, out_data.fired_id);
          fail_count++;
        end
        if (out_data.fired_data !== want.fired_data) begin
          $error("fired_data: expected %0h, got %0h", want.fired_data, out_data.fired_data);
          fail_count++;
        end
        if (out_data.last !== want.last) begin
          $error("last: expected %0h, got %0h", want.last, out_data.last);
          fail_count++;
        end
      end
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    logic [ID_W-1:0] id_pool [6];
    int r;
    logic [ID_W-1:0] id;
    logic [AUX_W-1:0] aux;
    int dly;
    id_pool = '{8'h00, 8'h01, 8'h80, 8'hFF, 8'h5A, 8'hA5};
    for (int i = 0; i < NSLOTS; i++) begin
      slot_tag[i] = '0;
      slot_on[i] = 1'b0;
      slot_rep[i] = 1'b0;
      slot_len[i] = '0;
      slot_word[i] = '0;
      slot_cnt[i] = '0;
    end

    // Directed: empty tick, id 0 hitting unused slots, full table, overflow,
    // reprogram keeping old aux, cancel and reuse of an inactive id, four alarms at once.
    pending_cmds.push_back(mk_cmd(CMD_TICK, 8'h00, 24'h000000, 32'h0));
    pending_cmds.push_back(mk_cmd(CMD_ACTIVATE, 8'h00, 24'h000001, 32'h0000_0001));
    pending_cmds.push_back(mk_cmd(CMD_TICK, 8'hFF, 24'hFFFFFF, 32'hFFFF_FFFF));
    pending_cmds.push_back(mk_cmd(CMD_ACTIVATE, 8'h5A, 24'h800002, 32'hDEAD_BEEF));
    pending_cmds.push_back(mk_cmd(CMD_ACTIVATE, 8'hFF, 24'h7FFFFF, 32'hFFFF_FFFF));
    pending_cmds.push_back(mk_cmd(CMD_ACTIVATE, 8'h33, 24'h800001, 32'h1234_5678));
    pending_cmds.push_back(mk_cmd(CMD_ACTIVATE, 8'h44, 24'h000003, 32'h0));
    pending_cmds.push_back(mk_cmd(CMD_ACTIVATE, 8'h77, 24'h000005, 32'h0BAD_F00D));
    pending_cmds.push_back(mk_cmd(CMD_ACTIVATE, 8'h77, 24'h000000, 32'h0));
    repeat (3) pending_cmds.push_back(mk_cmd(CMD_TICK, 8'h00, 24'h000000, 32'h0));
    pending_cmds.push_back(mk_cmd(CMD_ACTIVATE, 8'h5A, 24'h800004, 32'hAAAA_AAAA));
    pending_cmds.push_back(mk_cmd(CMD_ACTIVATE, 8'h33, 24'h000000, 32'h0));
    pending_cmds.push_back(mk_cmd(CMD_ACTIVATE, 8'h33, 24'h000002, 32'h5555_5555));
    pending_cmds.push_back(mk_cmd(CMD_ACTIVATE, 8'hFF, 24'h800000, 32'h0));
    pending_cmds.push_back(mk_cmd(CMD_ACTIVATE, 8'hFF, 24'h800001, 32'h0));
    pending_cmds.push_back(mk_cmd(CMD_ACTIVATE, 8'h5A, 24'h800001, 32'h0));
    pending_cmds.push_back(mk_cmd(CMD_ACTIVATE, 8'h33, 24'h800001, 32'h0));
    pending_cmds.push_back(mk_cmd(CMD_ACTIVATE, 8'h44, 24'h800001, 32'h0));
    pending_cmds.push_back(mk_cmd(CMD_TICK, 8'h00, 24'h000000, 32'h0));
    pending_cmds.push_back(mk_cmd(CMD_ACTIVATE, 8'h00, 24'h000000, 32'h0));
    pending_cmds.push_back(mk_cmd(CMD_ACTIVATE, 8'h44, 24'hFFFFFF, 32'hFFFF_FFFF));
    pending_cmds.push_back(mk_cmd(CMD_TICK, 8'h00, 24'h000000, 32'h0));

    // Random: mostly ticks and activations on a small id pool so slots collide and fire.
    for (int k = 0; k < 246; k++) begin
      r = $urandom_range(0, 99);
      id = id_pool[$urandom_range(0, 5)];
      aux = $urandom();
      if (r < 40) begin
        pending_cmds.push_back(mk_cmd(CMD_TICK, 8'($urandom_range(0, 255)),
                                      24'($urandom_range(0, 24'hFFFFFF)), aux));
      end else if (r < 50) begin
        pending_cmds.push_back(mk_cmd(CMD_ACTIVATE, id,
                                      {1'($urandom_range(0, 1)), 23'd0}, aux));
      end else if (r < 92) begin
        dly = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 60) : $urandom_range(1, 6);
        // Ids outside the pool stay one-shot so they cannot hold a slot forever.
        if ($urandom_range(0, 7) == 0) begin
          pending_cmds.push_back(mk_cmd(CMD_ACTIVATE, 8'($urandom_range(0, 255)),
                                        {1'b0, 23'(dly)}, aux));
        end else begin
          pending_cmds.push_back(mk_cmd(CMD_ACTIVATE, id,
                                        {1'($urandom_range(0, 1)), 23'(dly)}, aux));
        end
      end else begin
        pending_cmds.push_back(mk_cmd(1'($urandom_range(0, 1)), id,
                                      24'($urandom_range(0, 24'hFFFFFF)), aux));
      end
    end
    n_cmds = pending_cmds.size();

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (items_taken != n_cmds) @(posedge clk);
    while (alarm_results_q.size() != 0) @(posedge clk);
    repeat (4 * NSLOTS + 16) @(posedge clk);
    if (fail_count == 0 && alarm_results_q.size() == 0) begin
      $display("PASS multi_slot_alarm_timer_core");
    end else begin
      $display("FAIL multi_slot_alarm_timer_core");
    end
    $finish;
  end

  // Watchdog for a hung run.
  initial begin
    #2000000;
    $display("FAIL multi_slot_alarm_timer_core");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/msat_pkg.sv
rtl/msat_cell.sv
rtl/multi_slot_alarm_timer_core.sv
bench/tb.sv
